[src/index_start_position_selector_defines.svh]
// Assertion macros for the index start position selector.
// Used by the port checker; no other dependencies.
`ifndef INDEX_START_POSITION_SELECTOR_DEFINES_SVH
`define INDEX_START_POSITION_SELECTOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ISS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ISS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/iss_pkg.sv]
// Shared types, constants and the UTF-8 lead-byte function for the
// index start position selector. No dependencies.
package iss_pkg;

    // fixed field widths
    localparam int POS_W   = 32;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 3;
    localparam int SKIP_W  = 3;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 8;

    // separator registers and the usable count
    localparam int SEP_REGS       = 4;
    localparam int MAX_SEPARATORS = 4;
    localparam int SEP_LIMIT      = (MAX_SEPARATORS < SEP_REGS) ? MAX_SEPARATORS : SEP_REGS;

    // characters with a meaning of their own
    localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;
    localparam logic [BYTE_W-1:0] CH_NL  = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_UTF8  = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_COUNT = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_SEP_A = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_SEP_B = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_SEP_C = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_SEP_D = 3'd5;

    // reset values
    localparam logic [BYTE_W-1:0] SEP_RESET = 8'd32;

    typedef logic [BYTE_W-1:0] byte_t;

    // decoded mode, handed from the register file to the core
    typedef struct packed {
        logic                        utf8;
        logic                        tab_mode;
        logic                        all_mode;
        logic [SEP_REGS-1:0]         sep_en;
        byte_t [SEP_REGS-1:0]        seps;
    } cfg_t;

    // continuation bytes that follow a lead byte (six-byte scheme)
    function automatic logic [SKIP_W-1:0] lead_skip(input byte_t b);
        logic [SKIP_W-1:0] n;
        if (b < 8'hC0)      n = 3'd0;
        else if (b < 8'hE0) n = 3'd1;
        else if (b < 8'hF0) n = 3'd2;
        else if (b < 8'hF8) n = 3'd3;
        else if (b < 8'hFC) n = 3'd4;
        else if (b < 8'hFE) n = 3'd5;
        else                n = 3'd0;
        return n;
    endfunction

endpackage

[src/iss_in_if.sv]
// Input channel: one text byte per word with its start mark.
// Depends on iss_pkg.
interface iss_in_if;
    import iss_pkg::*;

    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   data_byte;
    logic                start_of_text;

    modport source (output valid, output data_byte, output start_of_text, input ready);
    modport sink   (input valid, input data_byte, input start_of_text, output ready);
endinterface

[src/iss_out_if.sv]
// Output channel: one start position per word.
// Depends on iss_pkg.
interface iss_out_if;
    import iss_pkg::*;

    logic                valid;
    logic                ready;
    logic [POS_W-1:0]    position;

    modport source (output valid, output position, input ready);
    modport sink   (input valid, input position, output ready);
endinterface

[src/iss_cfg.sv]
// Configuration registers and mode decode.
// Depends on iss_pkg.
module iss_cfg (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [7:0]             cfg_data,
    output iss_pkg::cfg_t          cfg
);
    import iss_pkg::*;

    logic                        utf8_reg;
    logic [CNT_W-1:0]            count_reg;
    byte_t [SEP_REGS-1:0]        seps_reg;
    logic [CNT_W-1:0]            lim;
    logic                        alive;
    logic [SEP_REGS-1:0]         en;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            utf8_reg  <= 1'b0;
            count_reg <= '0;
            for (int i = 0; i < SEP_REGS; i++)
            begin
                seps_reg[i] <= SEP_RESET;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_UTF8:  utf8_reg    <= cfg_data[0];
                CFG_COUNT: count_reg   <= cfg_data[CNT_W-1:0];
                CFG_SEP_A: seps_reg[0] <= cfg_data;
                CFG_SEP_B: seps_reg[1] <= cfg_data;
                CFG_SEP_C: seps_reg[2] <= cfg_data;
                CFG_SEP_D: seps_reg[3] <= cfg_data;
                default:   ;
            endcase
        end
    end

    // clip the count, then a zero separator ends the list
    always_comb
    begin
        lim   = (count_reg > CNT_W'(SEP_LIMIT)) ? CNT_W'(SEP_LIMIT) : count_reg;
        alive = 1'b1;
        for (int i = 0; i < SEP_REGS; i++)
        begin
            if (CNT_W'(i) >= lim) alive = 1'b0;
            if (seps_reg[i] == CH_NUL) alive = 1'b0;
            en[i] = alive;
        end
    end

    assign cfg.utf8     = utf8_reg;
    assign cfg.sep_en   = en;
    assign cfg.seps     = seps_reg;
    assign cfg.all_mode = !en[0];
    assign cfg.tab_mode = en[0] && (seps_reg[0] == CH_TAB);

endmodule

[src/iss_core.sv]
// Per-byte decision: offset counter, emit flag and UTF-8 skip count.
// Depends on iss_pkg.
module iss_core #(
    parameter int OFFSET_BITS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [7:0]                 data_byte,
    input  logic                       start_of_text,
    input  iss_pkg::cfg_t              cfg,
    output logic                       emit,
    output logic [OFFSET_BITS-1:0]     pos
);
    import iss_pkg::*;

    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic                   flag_reg, flag_next;
    logic [SKIP_W-1:0]      skip_reg, skip_next;
    logic                   flag_cur;
    logic [SKIP_W-1:0]      skip_cur;
    logic [SEP_REGS-1:0]    match;
    logic                   hit;

    // separator compare across the active list
    always_comb
    begin
        for (int i = 0; i < SEP_REGS; i++)
        begin
            match[i] = cfg.sep_en[i] && (data_byte == cfg.seps[i]);
        end
    end
    assign hit = |match;

    // start mark resets the state ahead of this byte
    assign pos      = start_of_text ? '0 : off_reg;
    assign flag_cur = start_of_text ? 1'b1 : flag_reg;
    assign skip_cur = start_of_text ? '0 : skip_reg;
    assign off_next = pos + OFFSET_BITS'(1);

    // mode decision
    always_comb
    begin
        emit      = 1'b0;
        flag_next = flag_cur;
        skip_next = skip_cur;
        if (cfg.utf8 && (skip_cur != '0))
        begin
            // continuation byte: nothing to report
            skip_next = skip_cur - SKIP_W'(1);
        end
        else
        begin
            if (cfg.utf8)
            begin
                skip_next = lead_skip(data_byte);
            end
            if (cfg.tab_mode)
            begin
                if (flag_cur && (data_byte == CH_TAB))
                begin
                    emit      = 1'b1;
                    flag_next = 1'b0;
                end
                else if (data_byte == CH_NL)
                begin
                    emit      = 1'b1;
                    flag_next = 1'b1;
                end
                else
                begin
                    emit = flag_cur;
                end
            end
            else if (cfg.utf8 || cfg.all_mode)
            begin
                emit = 1'b1;
            end
            else
            begin
                emit      = flag_cur;
                flag_next = hit;
            end
        end
    end

    // state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg  <= '0;
            flag_reg <= 1'b1;
            skip_reg <= '0;
        end
        else if (step)
        begin
            off_reg  <= off_next;
            flag_reg <= flag_next;
            skip_reg <= skip_next;
        end
    end

endmodule

[src/index_start_position_selector.sv]
// Top level of the index start position selector: input register, core,
// result register. Depends on iss_pkg, iss_in_if, iss_out_if, iss_cfg, iss_core.
//
//   channel   dir  payload                         handshake
//   in_ch     in   data_byte[7:0], start_of_text   valid/ready
//   out_ch    out  position[31:0]                  valid/ready
//   cfg       in   cfg_index[2:0], cfg_data[7:0]   cfg_we, no wait
//
// One byte per cycle while out_ch is not stalled; an accepted byte is held in
// the input register, and its position then goes to the result register.
// Bytes that give no position leave nothing on out_ch.
// Reset clears offset, skip count and valids and sets the emit flag.
// A stalled result holds one byte in the input register; in_ch stalls
// only when both registers are full.
module index_start_position_selector #(
    parameter int OFFSET_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    iss_in_if.sink        in_ch,
    iss_out_if.source     out_ch,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [7:0]    cfg_data
);
    import iss_pkg::*;

    iss_pkg::cfg_t                  cfg;
    logic                           s1_valid_reg, s1_valid_next;
    byte_t                          s1_byte_reg;
    logic                           s1_sot_reg;
    logic                           out_valid_reg, out_valid_next;
    logic [POS_W-1:0]               position_reg;
    logic                           s1_adv;
    logic                           in_acc;
    logic                           emit;
    logic [OFFSET_BITS-1:0]         pos;
    logic [POS_W+OFFSET_BITS-1:0]   pos_ext;

    iss_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    iss_core #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (s1_adv),
        .data_byte     (s1_byte_reg),
        .start_of_text (s1_sot_reg),
        .cfg           (cfg),
        .emit          (emit),
        .pos           (pos)
    );

    // handshake
    assign s1_adv      = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_adv;
    assign in_acc      = in_ch.valid && in_ch.ready;

    assign s1_valid_next  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_adv ? emit : (out_ch.ready ? 1'b0 : out_valid_reg);

    // position is the offset taken to 32 bits
    assign pos_ext = {{POS_W{1'b0}}, pos};

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_byte_reg <= in_ch.data_byte;
            s1_sot_reg  <= in_ch.start_of_text;
        end
        if (s1_adv && emit)
        begin
            position_reg <= pos_ext[POS_W-1:0];
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.position = position_reg;

endmodule

[src/iss_checker.sv]
// Port-level checks for the index start position selector, bound to the top.
// Depends on index_start_position_selector_defines.svh.
`include "index_start_position_selector_defines.svh"

module iss_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_ready,
    input  logic          out_valid,
    input  logic          out_ready,
    input  logic [31:0]   position
);

    // a waiting word stays valid
    `ISS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result word dropped while stalled")

    // a waiting word keeps its value
    `ISS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(position), "result word changed while stalled")

    // an empty result register never blocks the input
    `ISS_ASSERT_SAME(a_in_ready, clk, rst_n, !out_valid, in_ready, "input stalled with result register empty")

    // a new result comes from an accepted input byte
    `ISS_ASSERT_SAME(a_out_source, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 2), "result word without a matching input byte")

endmodule

bind index_start_position_selector iss_checker u_iss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .position  (out_ch.position)
);

[test/index_start_position_selector_tb.sv]
// Testbench for index_start_position_selector: streams text bytes through
// the input channel and checks each start position against a local predictor.
// Depends on iss_pkg, iss_in_if, iss_out_if and the top level of the block.
module index_start_position_selector_tb;
    import iss_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD     = 80;
    localparam int RANDOM_PHASES = 24;
    localparam int PHASE_BYTES   = 52;
    localparam int STALL_BYTES   = 40;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;

    iss_in_if  in_ch ();
    iss_out_if out_ch ();

    index_start_position_selector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow copy of the mode registers
    logic       mode_utf8;
    logic [2:0] mode_count;
    byte_t      mode_sep [SEP_REGS];

    // predictor state
    logic [POS_W-1:0] text_offset;
    logic             mark_pending;
    logic [2:0]       cont_left;

    logic [POS_W-1:0] expected_positions [$];

    int error_count = 0;
    int cycle_count = 0;
    int gap_style;
    int burst_left;
    bit long_hold_req;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // continuation bytes that follow a lead byte, six-byte scheme
    function automatic logic [2:0] cont_bytes(input byte_t b);
        logic [2:0] n;
        casez (b)
            8'b110?????: n = 3'd1;
            8'b1110????: n = 3'd2;
            8'b11110???: n = 3'd3;
            8'b111110??: n = 3'd4;
            8'b1111110?: n = 3'd5;
            default:     n = 3'd0;
        endcase
        return n;
    endfunction

    // separators in use: clipped to the limit, cut at the first zero byte
    function automatic int live_separators();
        int lim;
        int n;
        lim = (mode_count > SEP_LIMIT) ? SEP_LIMIT : mode_count;
        n = 0;
        while (n < lim && mode_sep[n] != CH_NUL)
            n++;
        return n;
    endfunction

    // works out the position (if any) that one accepted byte yields
    task automatic predict_position(input byte_t b, input logic sot);
        logic [POS_W-1:0] pos;
        int               nsep;
        logic             key_mode;
        logic             hit;
        if (sot)
        begin
            text_offset  = '0;
            mark_pending = 1'b1;
            cont_left    = 3'd0;
        end
        pos         = text_offset;
        text_offset = text_offset + 1'b1;
        nsep        = live_separators();
        key_mode    = (nsep > 0) && (mode_sep[0] == CH_TAB);
        hit         = 1'b0;
        if (mode_utf8 && cont_left != 3'd0)
            cont_left = cont_left - 3'd1;
        else
        begin
            if (mode_utf8)
                cont_left = cont_bytes(b);
            if (key_mode)
            begin
                if (mark_pending && b == CH_TAB)
                begin
                    hit          = 1'b1;
                    mark_pending = 1'b0;
                end
                else if (b == CH_NL)
                begin
                    hit          = 1'b1;
                    mark_pending = 1'b1;
                end
                else if (mark_pending)
                    hit = 1'b1;
            end
            else if (mode_utf8 || nsep == 0)
                hit = 1'b1;
            else
            begin
                if (mark_pending)
                begin
                    hit          = 1'b1;
                    mark_pending = 1'b0;
                end
                for (int i = 0; i < nsep; i++)
                    if (b == mode_sep[i])
                        mark_pending = 1'b1;
            end
            if (hit)
                expected_positions.insert(expected_positions.size(), pos);
        end
    endtask

    // predict on every accepted byte
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            predict_position(in_ch.data_byte, in_ch.start_of_text);
    end

    // compare every accepted position with the oldest expectation
    always @(posedge clk)
    begin
        logic [POS_W-1:0] want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_positions.size() == 0)
            begin
                $display("%0t: unexpected position, expected none, actual %0d",
                         $time, out_ch.position);
                error_count++;
            end
            else
            begin
                want = expected_positions.pop_front();
                if (out_ch.position !== want)
                begin
                    $display("%0t: position mismatch, expected %0d, actual %0d",
                             $time, want, out_ch.position);
                    error_count++;
                end
            end
        end
    end

    // receiver: changing stall pattern, plus a long hold-off on request
    initial
    begin
        int hold_left;
        int pattern_left;
        int pattern;
        hold_left    = 0;
        pattern_left = 0;
        pattern      = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    pattern      = $urandom_range(0, 2);
                    pattern_left = $urandom_range(16, 96);
                end
                pattern_left--;
                case (pattern)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= 1'($urandom_range(0, 1));
                    default: out_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // one register write; the shadow copy follows at the write edge
    task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            CFG_UTF8:  mode_utf8   = value[0];
            CFG_COUNT: mode_count  = value[2:0];
            CFG_SEP_A: mode_sep[0] = value;
            CFG_SEP_B: mode_sep[1] = value;
            CFG_SEP_C: mode_sep[2] = value;
            CFG_SEP_D: mode_sep[3] = value;
            default: ;
        endcase
    endtask

    task automatic set_mode(input logic u, input logic [2:0] cnt,
                            input byte_t a, input byte_t b, input byte_t c, input byte_t d);
        write_reg(CFG_UTF8, {7'd0, u});
        write_reg(CFG_COUNT, {5'd0, cnt});
        write_reg(CFG_SEP_A, a);
        write_reg(CFG_SEP_B, b);
        write_reg(CFG_SEP_C, c);
        write_reg(CFG_SEP_D, d);
        cfg_we <= 1'b0;
    endtask

    // sends one word, idling between bursts according to gap_style
    task automatic send_byte(input byte_t b, input logic sot);
        int gap;
        if (gap_style != 0)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, (gap_style == 1) ? 16 : 4);
                gap        = $urandom_range(1, (gap_style == 1) ? 3 : 8);
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left--;
        end
        in_ch.valid         <= 1'b1;
        in_ch.data_byte     <= b;
        in_ch.start_of_text <= sot;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // stop sending, let every expected position arrive, then settle
    task automatic quiesce();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_positions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic byte_t pick_sep();
        byte_t s;
        case ($urandom_range(0, 9))
            0:       s = CH_TAB;
            1:       s = 8'd1;
            2:       s = 8'd255;
            3:       s = CH_NUL;
            4:       s = CH_NL;
            5:       s = 8'h2C;
            default: s = byte_t'($urandom_range(1, 255));
        endcase
        return s;
    endfunction

    function automatic logic next_sot(input int sent, input logic first_sot);
        return (sent == 0 && first_sot) || ($urandom_range(0, 99) == 0);
    endfunction

    // text of roughly n bytes: separators, tabs, newlines, characters, noise
    task automatic send_text(input int n, input logic first_sot);
        int    sent;
        int    kind;
        int    len;
        byte_t lead;
        sent = 0;
        while (sent < n)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 12)
                send_byte(mode_sep[$urandom_range(0, SEP_REGS - 1)], next_sot(sent, first_sot));
            else if (kind < 20)
                send_byte(CH_TAB, next_sot(sent, first_sot));
            else if (kind < 28)
                send_byte(CH_NL, next_sot(sent, first_sot));
            else if (kind < 34)
                send_byte(byte_t'($urandom_range(0, 255)), next_sot(sent, first_sot));
            else if (mode_utf8)
            begin
                // well-formed character, lead then continuation bytes
                kind = $urandom_range(0, 19);
                len  = (kind < 8) ? 1 : (kind < 13) ? 2 : (kind < 16) ? 3 :
                       (kind < 18) ? 4 : (kind == 18) ? 5 : 6;
                case (len)
                    1:       lead = byte_t'($urandom_range(8'h20, 8'h7E));
                    2:       lead = byte_t'($urandom_range(8'hC0, 8'hDF));
                    3:       lead = byte_t'($urandom_range(8'hE0, 8'hEF));
                    4:       lead = byte_t'($urandom_range(8'hF0, 8'hF7));
                    5:       lead = byte_t'($urandom_range(8'hF8, 8'hFB));
                    default: lead = byte_t'($urandom_range(8'hFC, 8'hFD));
                endcase
                send_byte(lead, next_sot(sent, first_sot));
                for (int i = 1; i < len; i++)
                begin
                    sent++;
                    send_byte(byte_t'($urandom_range(8'h80, 8'hBF)), 1'b0);
                end
            end
            else
                send_byte(byte_t'($urandom_range(8'h20, 8'h7E)), next_sot(sent, first_sot));
            sent++;
        end
    endtask

    // reset mode: every offset, start mark restarts the count
    task automatic test_all_positions();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h41, 1'b1);
        quiesce();
    endtask

    // key field up to the first tab, every newline, second tab silent
    task automatic test_key_field();
        set_mode(1'b0, 3'd1, CH_TAB, SEP_RESET, SEP_RESET, SEP_RESET);
        send_byte(8'h6B, 1'b1);
        send_byte(CH_TAB, 1'b0);
        send_byte(8'h76, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_NL, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_NL, 1'b0);
        quiesce();
    endtask

    // count above the limit, extreme separator bytes, then a zero separator
    task automatic test_separators();
        set_mode(1'b0, 3'd7, 8'h2C, 8'd255, 8'd1, 8'h20);
        send_byte(8'h61, 1'b1);
        send_byte(8'h2C, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h62, 1'b0);
        quiesce();
        // zero in the second slot drops it and everything after
        set_mode(1'b0, 3'd4, 8'h2C, CH_NUL, 8'd255, 8'h20);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h64, 1'b0);
        quiesce();
    endtask

    // character starts only; offset carries on from the previous setting
    task automatic test_utf8();
        set_mode(1'b1, 3'd0, CH_NUL, SEP_RESET, SEP_RESET, SEP_RESET);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hFC, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'h83, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        quiesce();
    endtask

    // long receiver hold-off while words keep coming
    task automatic test_output_stall();
        set_mode(1'b0, 3'd0, SEP_RESET, SEP_RESET, SEP_RESET, SEP_RESET);
        gap_style     = 0;
        long_hold_req = 1'b1;
        for (int i = 0; i < STALL_BYTES; i++)
            send_byte(byte_t'($urandom_range(0, 255)), 1'b0);
        quiesce();
    endtask

    // random settings per phase, extremes in the first few
    task automatic test_random_text();
        logic       u;
        logic [2:0] cnt;
        byte_t      a;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            u   = 1'($urandom_range(0, 1));
            cnt = 3'($urandom_range(0, 7));
            a   = ($urandom_range(0, 2) == 0) ? CH_TAB : pick_sep();
            if (p == 0)
                cnt = 3'd0;
            else if (p == 1)
                cnt = 3'd4;
            else if (p == 2)
                cnt = 3'd7;
            set_mode(u, cnt, a, pick_sep(), pick_sep(), pick_sep());
            gap_style = p % 3;
            send_text(PHASE_BYTES, $urandom_range(0, 2) == 0);
            quiesce();
        end
    endtask

    initial
    begin
        in_ch.valid         = 1'b0;
        in_ch.data_byte     = '0;
        in_ch.start_of_text = 1'b0;
        out_ch.ready        = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        rst_n               = 1'b0;
        mode_utf8           = 1'b0;
        mode_count          = 3'd0;
        foreach (mode_sep[i])
            mode_sep[i] = SEP_RESET;
        text_offset   = '0;
        mark_pending  = 1'b1;
        cont_left     = 3'd0;
        gap_style     = 0;
        burst_left    = 0;
        long_hold_req = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_all_positions();
        test_key_field();
        test_separators();
        test_utf8();
        test_output_stall();
        test_random_text();

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
